FILE: rtl/pes_pkg.sv
// Package for the pendulum step block: constants, codes and helper functions.
package pes_pkg;

  localparam int FRAC_BITS_DEF = 20;

  localparam int GRAV_W = 24;
  localparam int LEN_W  = 11;
  localparam int DT_W   = 24;
  localparam int CFG_W  = 24;

  localparam logic [GRAV_W-1:0] GRAVITY_RST = 24'd642908;
  localparam logic [LEN_W-1:0]  LENGTH_RST  = 11'd300;

  typedef enum logic [0:0] {
    REG_GRAVITY = 1'b0,
    REG_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    FN_ADVANCE = 1'b0,
    FN_LOAD    = 1'b1
  } func_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // magnitude of a 32-bit signed value, one bit wider
  function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return v[31] ? -e : e;
  endfunction

endpackage

FILE: rtl/pendulum_euler_step.sv
// Pendulum bob state and one semi-implicit Euler step per item, iterative datapath.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per step. in_func selects
//   advance (integrate one step of in_time_step seconds) or load (set the
//   position from in_load_x / in_load_y, velocity cleared).
//   Result channel (out_valid / out_stall): one item per input item carrying
//   the position and velocity after that item.
//   Config port: cfg_we, cfg_index (0 gravity, 1 string length), cfg_data.
//   Write only while the block is idle.
// Operation:
//   A load item gives its result in the cycle after acceptance. An advance item
//   with zero velocity skips the root and the divisions; otherwise a 32-step
//   square root and three 64-step restoring divisions (only the v^2/length one
//   with the bob at the anchor) run on the shared divide/root unit, and up to
//   thirteen products go through one shared 33x33 multiplier. One item at a
//   time; in_stall is high from acceptance until the result has been taken.
// Reset: rst_n (synchronous) clears position and velocity and restores the
//   default gravity (9.81) and length (300 m). A stalled result simply holds.
module pendulum_euler_step #(
  parameter int FRAC_BITS = pes_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [pes_pkg::DT_W-1:0]    in_time_step,
  input  logic signed [31:0]          in_load_x,
  input  logic signed [31:0]          in_load_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_pos_x_out,
  output logic signed [31:0]          out_pos_y_out,
  output logic signed [31:0]          out_vel_x_out,
  output logic signed [31:0]          out_vel_y_out,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pes_pkg::CFG_W-1:0]   cfg_data
);
  import pes_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [24:0] {
    ST_IDLE = 25'd1 << 0,
    ST_MV0  = 25'd1 << 1,
    ST_MV1  = 25'd1 << 2,
    ST_MV2  = 25'd1 << 3,
    ST_MP1  = 25'd1 << 4,
    ST_MP2  = 25'd1 << 5,
    ST_SQRT = 25'd1 << 6,
    ST_DIVX = 25'd1 << 7,
    ST_DIVY = 25'd1 << 8,
    ST_DIVV = 25'd1 << 9,
    ST_MG   = 25'd1 << 10,
    ST_CC   = 25'd1 << 11,
    ST_MCX  = 25'd1 << 12,
    ST_MCY  = 25'd1 << 13,
    ST_AY   = 25'd1 << 14,
    ST_AXH  = 25'd1 << 15,
    ST_AXL  = 25'd1 << 16,
    ST_AYH  = 25'd1 << 17,
    ST_AYL  = 25'd1 << 18,
    ST_PX   = 25'd1 << 19,
    ST_PY   = 25'd1 << 20,
    ST_PUP  = 25'd1 << 21,
    ST_OUT  = 25'd1 << 22,
    ST_SPR1 = 25'd1 << 23,
    ST_SPR2 = 25'd1 << 24
  } state_t;

  state_t state_r, state_nxt;

  logic [GRAV_W-1:0]  gravity_r;
  logic [LEN_W-1:0]   length_r;
  logic [DT_W-1:0]    dt_r, dt_nxt;
  logic signed [31:0] bob_x_r, bob_x_nxt, bob_y_r, bob_y_nxt;
  logic signed [31:0] speed_x_r, speed_x_nxt, speed_y_r, speed_y_nxt;
  logic [63:0]        v2_r, v2_nxt;
  logic [63:0]        rem_r, rem_nxt;   // root remainder / divide remainder
  logic [63:0]        res_r, res_nxt;   // root result / divide numerator-quotient
  logic [63:0]        den_r, den_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [31:0]        len_r, len_nxt;
  logic signed [32:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [63:0]        qv_r, qv_nxt;
  logic signed [31:0] c_r, c_nxt;
  logic signed [63:0] ax_r, ax_nxt, ay_r, ay_nxt, acc_r, acc_nxt;
  logic signed [63:0] prod_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // gravity in the state's fixed-point format
  logic signed [63:0] gf;
  assign gf = $signed(({{(64-GRAV_W){1'b0}}, gravity_r} << FRAC_BITS) >> 16);

  logic [63:0] len_ext;
  assign len_ext = {{(64-LEN_W){1'b0}}, ((length_r == '0) ? {{(LEN_W-1){1'b0}}, 1'b1} : length_r)};

  // shared root / divide step
  logic [63:0] sq_bit, sq_try, dv_try;
  logic [63:0] sq_rem, sq_res, dv_rem, dv_res;
  always_comb begin
    sq_bit = 64'h4000_0000_0000_0000 >> {cnt_r[4:0], 1'b0};
    sq_try = res_r + sq_bit;
    if (rem_r >= sq_try) begin
      sq_rem = rem_r - sq_try;
      sq_res = (res_r >> 1) + sq_bit;
    end else begin
      sq_rem = rem_r;
      sq_res = res_r >> 1;
    end
    dv_try = {rem_r[62:0], res_r[63]};
    if (dv_try >= den_r) begin
      dv_rem = dv_try - den_r;
      dv_res = {res_r[62:0], 1'b1};
    end else begin
      dv_rem = dv_try;
      dv_res = {res_r[62:0], 1'b0};
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  logic [63:0]        v2_sum, sq_sum;
  logic signed [63:0] csum, dsum, q_s;
  logic [63:0]        dv_q_abs;

  always_comb begin
    state_nxt   = state_r;
    dt_nxt      = dt_r;
    bob_x_nxt   = bob_x_r;
    bob_y_nxt   = bob_y_r;
    speed_x_nxt = speed_x_r;
    speed_y_nxt = speed_y_r;
    v2_nxt      = v2_r;
    rem_nxt     = rem_r;
    res_nxt     = res_r;
    den_nxt     = den_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    qv_nxt      = qv_r;
    c_nxt       = c_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    acc_nxt     = acc_r;
    mul_a       = '0;
    mul_b       = '0;
    v2_sum      = v2_r + prod_r;
    sq_sum      = rem_r + prod_r;
    csum        = (prod_r >>> 16) + $signed(qv_r);
    dsum        = acc_r + prod_r;
    dv_q_abs    = dv_res;
    q_s         = $signed(dv_res);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dt_nxt = in_time_step;
          if (in_func == FN_LOAD) begin
            bob_x_nxt   = in_load_x;
            bob_y_nxt   = in_load_y;
            speed_x_nxt = '0;
            speed_y_nxt = '0;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_MV0;
          end
        end
      end
      ST_MV0: begin
        mul_a = abs33(speed_x_r);
        mul_b = abs33(speed_x_r);
        state_nxt = ST_MV1;
      end
      ST_MV1: begin
        v2_nxt = prod_r;
        mul_a = abs33(speed_y_r);
        mul_b = abs33(speed_y_r);
        state_nxt = ST_MV2;
      end
      ST_MV2: begin
        v2_nxt = v2_sum;
        mul_a = abs33(bob_x_r);
        mul_b = abs33(bob_x_r);
        if (v2_sum == '0) begin
          ax_nxt = '0;
          ay_nxt = gf;
          state_nxt = ST_AXH;
        end else begin
          state_nxt = ST_MP1;
        end
      end
      ST_MP1: begin
        rem_nxt = prod_r;
        mul_a = abs33(bob_y_r);
        mul_b = abs33(bob_y_r);
        state_nxt = ST_MP2;
      end
      ST_MP2: begin
        rem_nxt = sq_sum;
        res_nxt = '0;
        cnt_nxt = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        rem_nxt = sq_rem;
        res_nxt = sq_res;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          len_nxt = sq_res[31:0];
          cnt_nxt = '0;
          rem_nxt = '0;
          if (sq_res == '0) begin
            nx_nxt  = '0;
            ny_nxt  = '0;
            res_nxt = v2_r;
            den_nxt = len_ext << FRAC_BITS;
            state_nxt = ST_DIVV;
          end else begin
            res_nxt = {{31{1'b0}}, abs33(bob_x_r)} << FRAC_BITS;
            den_nxt = {32'd0, sq_res[31:0]};
            state_nxt = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        rem_nxt = dv_rem;
        res_nxt = dv_res;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          nx_nxt  = bob_x_r[31] ? -q_s[32:0] : q_s[32:0];
          rem_nxt = '0;
          res_nxt = {{31{1'b0}}, abs33(bob_y_r)} << FRAC_BITS;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        rem_nxt = dv_rem;
        res_nxt = dv_res;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          ny_nxt  = bob_y_r[31] ? -q_s[32:0] : q_s[32:0];
          rem_nxt = '0;
          res_nxt = v2_r;
          den_nxt = len_ext << FRAC_BITS;
          state_nxt = ST_DIVV;
        end
      end
      ST_DIVV: begin
        rem_nxt = dv_rem;
        res_nxt = dv_res;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          qv_nxt = dv_q_abs;
          state_nxt = ST_MG;
        end
      end
      ST_MG: begin
        mul_a = $signed({{(33-GRAV_W){1'b0}}, gravity_r});
        mul_b = ny_r;
        state_nxt = ST_CC;
      end
      ST_CC: begin
        c_nxt = sat32(csum);
        state_nxt = ST_MCX;
      end
      ST_MCX: begin
        mul_a = {c_r[31], c_r};
        mul_b = nx_r;
        state_nxt = ST_MCY;
      end
      ST_MCY: begin
        ax_nxt = -(prod_r >>> FRAC_BITS);
        mul_a = {c_r[31], c_r};
        mul_b = ny_r;
        state_nxt = ST_AY;
      end
      ST_AY: begin
        ay_nxt = gf - (prod_r >>> FRAC_BITS);
        state_nxt = ST_AXH;
      end
      ST_AXH: begin
        mul_a = ax_r[48:16];
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_AXL;
      end
      ST_AXL: begin
        acc_nxt = prod_r <<< 16;
        mul_a = $signed({17'd0, ax_r[15:0]});
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_AYH;
      end
      ST_AYH: begin
        speed_x_nxt = sat32($signed({{32{speed_x_r[31]}}, speed_x_r}) + (dsum >>> 24));
        mul_a = ay_r[48:16];
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_AYL;
      end
      ST_AYL: begin
        acc_nxt = prod_r <<< 16;
        mul_a = $signed({17'd0, ay_r[15:0]});
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_PX;
      end
      ST_PX: begin
        speed_y_nxt = sat32($signed({{32{speed_y_r[31]}}, speed_y_r}) + (dsum >>> 24));
        mul_a = {speed_x_r[31], speed_x_r};
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_PY;
      end
      ST_PY: begin
        bob_x_nxt = sat32($signed({{32{bob_x_r[31]}}, bob_x_r}) + (prod_r >>> 24));
        mul_a = {speed_y_r[31], speed_y_r};
        mul_b = $signed({{(33-DT_W){1'b0}}, dt_r});
        state_nxt = ST_PUP;
      end
      ST_PUP: begin
        bob_y_nxt = sat32($signed({{32{bob_y_r[31]}}, bob_y_r}) + (prod_r >>> 24));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RST;
      length_r  <= LENGTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRAVITY) begin
        gravity_r <= cfg_data[GRAV_W-1:0];
      end else begin
        length_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  // control and pendulum state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bob_x_r   <= '0;
      bob_y_r   <= '0;
      speed_x_r <= '0;
      speed_y_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      bob_x_r   <= bob_x_nxt;
      bob_y_r   <= bob_y_nxt;
      speed_x_r <= speed_x_nxt;
      speed_y_r <= speed_y_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    v2_r   <= v2_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    den_r  <= den_nxt;
    len_r  <= len_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    qv_r   <= qv_nxt;
    c_r    <= c_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    acc_r  <= acc_nxt;
    prod_r <= mul_p[63:0];
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_pos_x_out = bob_x_r;
  assign out_pos_y_out = bob_y_r;
  assign out_vel_x_out = speed_x_r;
  assign out_vel_y_out = speed_y_r;

  // a load item is answered in the very next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == FN_LOAD) |=> out_valid)
    else $error("load item not answered next cycle");

  // no item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");

  // root runs 32 steps only
  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (cnt_r[5] == 1'b0))
    else $error("root step count out of range");

  // a taken result returns the block to idle
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> !out_valid && !in_stall)
    else $error("block not idle after result taken");

  // the x divisor is the root length
  a_len_dv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVX) |-> (den_r == {32'd0, len_r}))
    else $error("divisor differs from root length");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for pendulum_euler_step: predicted step results against the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pes_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } bob_state_t;

  // Tracks the bob, predicts every step and compares the block's results.
  class pendulum_scoreboard;
    bob_state_t   bob;
    logic [23:0]  grav;
    logic [10:0]  len_m;
    bob_state_t   pending[$];
    int           errors;
    int           checked;

    function new();
      bob = '0;
      grav = GRAVITY_RST;
      len_m = LENGTH_RST;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] magn(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic signed [63:0] unit_comp(logic signed [63:0] p, logic [63:0] l);
      logic [63:0] q;
      q = (magn(p) << FRAC_BITS_DEF) / l;
      return p < 0 ? -$signed(q) : $signed(q);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] val);
      if (idx == REG_GRAVITY) grav = val;
      else len_m = val[10:0];
    endfunction

    function void note_input(func_t fn, logic [23:0] dt, logic signed [31:0] lx,
                             logic signed [31:0] ly);
      logic signed [63:0] px, py, vx, vy, gf, ax, ay, nx, ny, c, sdt;
      logic [63:0] v2, l, lm;
      if (fn == FN_LOAD) begin
        bob.pos_x = lx;
        bob.pos_y = ly;
        bob.vel_x = 0;
        bob.vel_y = 0;
      end else begin
        px = bob.pos_x; py = bob.pos_y; vx = bob.vel_x; vy = bob.vel_y;
        sdt = $signed({40'd0, dt});
        gf = $signed(({40'd0, grav} << FRAC_BITS_DEF) >> 16);
        v2 = magn(vx) * magn(vx) + magn(vy) * magn(vy);
        ax = 0;
        ay = gf;
        if (v2 != 0) begin
          l = root64(magn(px) * magn(px) + magn(py) * magn(py));
          nx = 0; ny = 0;
          lm = (len_m == 0) ? 64'd1 : {53'd0, len_m};
          if (l != 0) begin
            nx = unit_comp(px, l);
            ny = unit_comp(py, l);
          end
          c = ($signed({40'd0, grav}) * ny) >>> 16;
          c = c + $signed(v2 / (lm << FRAC_BITS_DEF));
          c = clamp32(c);
          ax = -((c * nx) >>> FRAC_BITS_DEF);
          ay = gf - ((c * ny) >>> FRAC_BITS_DEF);
        end
        vx = clamp32(vx + ((ax * sdt) >>> 24));
        vy = clamp32(vy + ((ay * sdt) >>> 24));
        px = clamp32(px + ((vx * sdt) >>> 24));
        py = clamp32(py + ((vy * sdt) >>> 24));
        bob.pos_x = px[31:0]; bob.pos_y = py[31:0];
        bob.vel_x = vx[31:0]; bob.vel_y = vy[31:0];
      end
      pending.push_back(bob);
    endfunction

    task check_result(bob_state_t got);
      bob_state_t want;
      if (pending.size() == 0) begin
        report("result item with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.vel_x !== want.vel_x || got.vel_y !== want.vel_y)
        report($sformatf("item %0d pos (%h,%h) vel (%h,%h), want pos (%h,%h) vel (%h,%h)",
                         checked, got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                         want.pos_x, want.pos_y, want.vel_x, want.vel_y));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic [DT_W-1:0] in_time_step;
  logic signed [31:0] in_load_x;
  logic signed [31:0] in_load_y;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_pos_x_out;
  logic signed [31:0] out_pos_y_out;
  logic signed [31:0] out_vel_x_out;
  logic signed [31:0] out_vel_y_out;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pendulum_scoreboard sb;
  int send_idle_pct;   // chance of a gap before each item
  int recv_stall_pct;  // chance of out_stall in any cycle
  int loads_sent, advances_sent;

  pendulum_euler_step DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout: far beyond the slowest legal run, even with heavy stalls.
  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall, results sampled on the accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out});
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Drive one item; in_valid is left high so back-to-back items need no re-raise.
  task send_item(func_t fn, logic [23:0] dt, logic signed [31:0] lx, logic signed [31:0] ly);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_time_step <= dt;
    in_load_x    <= lx;
    in_load_y    <= ly;
    do @(posedge clk); while (in_stall);
    sb.note_input(fn, dt, lx, ly);
    if (fn == FN_LOAD) loads_sent++;
    else advances_sent++;
  endtask

  task load_bob(logic signed [31:0] x, logic signed [31:0] y);
    send_item(FN_LOAD, 24'($urandom), x, y);
  endtask

  task advance_bob(logic [23:0] dt);
    send_item(FN_ADVANCE, dt, $urandom, $urandom);
  endtask

  // Wait until every expected item is back, then let the block settle.
  task drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Only called with the block idle.
  task write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function logic signed [31:0] rand_coord();
    // spread magnitudes from tiny to full range
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function logic [23:0] rand_dt();
    return 24'($urandom) >> $urandom_range(0, 16);
  endfunction

  logic [23:0] grav_set[6] = '{24'd642908, 24'd0, 24'hFFFFFF, 24'd65536, 24'd642908, 24'd1600000};
  logic [23:0] len_set[6]  = '{24'd1, 24'd1024, 24'd0, 24'd2047, 24'd5, 24'd300};
  int idle_set[4] = '{0, 71, 0, 28};
  int stall_set[4] = '{0, 0, 71, 28};

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_func = FN_ADVANCE; in_time_step = '0;
    in_load_x = '0; in_load_y = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_GRAVITY; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    loads_sent = 0; advances_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: advance from reset (zero speed), bob at the anchor while moving,
    // field extremes and saturation of position and velocity.
    advance_bob(24'd0);
    advance_bob(24'd4096);
    advance_bob(24'd4096);        // speed non-zero, position still at the anchor
    advance_bob(24'hFFFFFF);
    load_bob(32'sh7FFF_FFFF, 32'sh8000_0000);
    advance_bob(24'hFFFFFF);
    advance_bob(24'hFFFFFF);
    load_bob(32'sh8000_0000, 32'sh7FFF_FFFF);
    repeat (4) advance_bob(24'hFFFFFF);
    load_bob(32'sd0, 32'sd0);
    repeat (3) advance_bob(24'hFFFFFF);
    load_bob(32'sd3 <<< 20, 32'sd4 <<< 20);
    repeat (4) advance_bob(24'h040000);
    load_bob(-32'sd1, 32'sd1);
    advance_bob(24'h000001);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRAVITY, grav_set[ph]);
      write_reg(REG_LENGTH, len_set[ph]);
      send_idle_pct  = idle_set[ph % 4];
      recv_stall_pct = stall_set[ph % 4];
      for (int n = 0; n < 300; ) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any item with arbitrary content
          send_item(func_t'($urandom_range(0, 1)), 24'($urandom), $urandom, $urandom);
          n++;
        end else begin
          // swing: a load at a random spot followed by a run of steps
          load_bob(rand_coord(), rand_coord());
          n++;
          for (int k = $urandom_range(4, 20); k > 0; k--) begin
            advance_bob(rand_dt());
            n++;
          end
        end
      end
      drain();
    end
    // one short phase with no idling at all, default registers restored
    send_idle_pct = 0; recv_stall_pct = 0;
    write_reg(REG_GRAVITY, GRAVITY_RST);
    write_reg(REG_LENGTH, LENGTH_RST);
    load_bob(32'sd1 <<< 20, 32'sd2 <<< 20);
    repeat (10) advance_bob(rand_dt());
    drain();

    $display("covered %0d load and %0d advance items over 7 register settings",
             loads_sent, advances_sent);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/pes_pkg.sv
rtl/pendulum_euler_step.sv
test/testbench.sv
